/* src/fla_pkg.sv */
// Shared types, constants and helpers for the free-region allocator.
// Used by fla_engine and free_list_allocator_unit; no dependencies.
package fla_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  localparam logic [31:0] PageMask = 32'h0000_0fff;
  localparam logic [31:0] PageBase = 32'hffff_f000;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_DROP  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ASCAN,
    ST_FSCAN,
    ST_FDEC,
    ST_FMERGE,
    ST_SHIFT,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] addr;
    logic [31:0] size;
  } req_t;

  typedef struct packed {
    logic [31:0]     granted_addr;
    logic [1:0]      status;
    logic [31:0]     free_total;
    logic [CntW-1:0] entries_used;
    logic [CntW-1:0] peak_entries;
    logic [31:0]     lost_blocks;
    logic [31:0]     lost_bytes;
  } rsp_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

endpackage

/* src/free_list_allocator_unit.sv */
// Top level of the free-region allocator: stream ports, page rounding, result register.
// Depends on fla_pkg and fla_engine.
//
// First-fit allocator over a 64-entry table of free regions sorted by address. Each
// input word (tuser = mode: 0 allocate, 1 free, 2 or 3 query) runs one request through
// a region table under a sequencer, one table read and one table write per cycle: a scan
// to the matching entry, an optional shift of the entries above it (remove or insert),
// then a pass that sums the free bytes, with tready low until the request is done. One
// result word is held in an output register, so the next request is taken while it waits.
module free_list_allocator_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,     // round_to_page
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [63:0]    s_axis_tdata_i,  // block_addr[31:0], block_size[63:32]
  input  logic [1:0]     s_axis_tuser_i,  // mode
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [143:0]   m_axis_tdata_o,  // granted_addr, free_total, entries_used,
                                          // peak_entries, lost_blocks, lost_bytes, zero pad
  output logic [1:0]     m_axis_tuser_o   // status
);
  import fla_pkg::*;

  logic          round_q;
  logic          out_vld_q;
  rsp_t          out_q;
  req_t          req;
  rsp_t          rsp;
  logic          eng_ready, rsp_valid, rsp_ready;
  logic [31:0]   size_in;

  assign size_in = s_axis_tdata_i[63:32];

  always_comb begin
    req.mode = s_axis_tuser_i;
    req.addr = s_axis_tdata_i[31:0];
    if (!round_q) req.size = size_in;
    else if (size_in > PageBase) req.size = PageBase;
    else req.size = (size_in + PageMask) & PageBase;
  end

  fla_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_i       (req),
    .req_ready_o (eng_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  assign s_axis_tready_o = eng_ready;
  assign rsp_ready       = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) round_q <= cfg_wdata_i;
      if (rsp_ready) out_vld_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) out_q <= rsp;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {2'b00, out_q.lost_bytes, out_q.lost_blocks, out_q.peak_entries,
                            out_q.entries_used, out_q.free_total, out_q.granted_addr};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken again right after accept");
  a_entries_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_q.entries_used <= CntW'(TableEntries)
                         && out_q.entries_used <= out_q.peak_entries))
    else $error("entry count out of range");
  a_fail_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_q.status != STAT_OK) |-> out_q.granted_addr == '0)
    else $error("failed request reports an address");
`endif

endmodule

/* src/fla_engine.sv */
// Region table, sequencer and statistics of the free-region allocator.
// Depends on fla_pkg.
module fla_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  fla_pkg::req_t req_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output fla_pkg::rsp_t rsp_o
);
  import fla_pkg::*;

  logic [63:0] mem [TableEntries];
  logic [63:0] rdata_q;
  logic            re, we;
  logic [IdxW-1:0] raddr, waddr;
  logic [63:0]     wdata;

  state_e state_q, state_d;
  logic            pend_q;
  logic [CntW-1:0] ptr_q, ptr_d, idx_q, idx_d, rem_q, rem_d, nx_q, nx_d;
  logic [CntW-1:0] count_q, count_d, peak_q, peak_d;
  logic [IdxW-1:0] ra_q, ra_d;
  logic            up_q, up_d, cur_vld_q, cur_vld_d;
  logic [1:0]      mode_q, mode_d, status_q, status_d;
  logic [31:0]     addr_q, addr_d, size_q, size_d;
  logic [31:0]     prev_s_q, prev_s_d, prev_l_q, prev_l_d, cur_s_q, cur_s_d, cur_l_q, cur_l_d;
  logic [31:0]     dropc_q, dropc_d, dropb_q, dropb_d, total_q, total_d;
  logic [31:0]     granted_q, granted_d;

  logic [31:0] rstart, rlen;
  logic        more, a_hit, a_exact, f_gt;
  logic        has_prev, prev_touch, cur_touch, room;
  logic [32:0] prev_end, blk_end;

  assign rstart     = rdata_q[31:0];
  assign rlen       = rdata_q[63:32];
  assign more       = ptr_q < count_q;
  assign a_hit      = pend_q && (rlen >= size_q);
  assign a_exact    = rlen == size_q;
  assign f_gt       = pend_q && (rstart > addr_q);
  assign has_prev   = idx_q != '0;
  assign prev_end   = {1'b0, prev_s_q} + {1'b0, prev_l_q};
  assign blk_end    = {1'b0, addr_q} + {1'b0, size_q};
  assign prev_touch = has_prev && (prev_end == {1'b0, addr_q});
  assign cur_touch  = cur_vld_q && (blk_end == {1'b0, cur_s_q});
  assign room       = count_q < CntW'(TableEntries);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (req_i.mode == MODE_ALLOC) state_d = ST_ASCAN;
          else if (req_i.mode == MODE_FREE) state_d = ST_FSCAN;
          else state_d = ST_SUM;
        end
      end
      ST_ASCAN: begin
        if (a_hit) state_d = a_exact ? ST_SHIFT : ST_SUM;
        else if (!more) state_d = ST_SUM;
      end
      ST_FSCAN: begin
        if (f_gt || !more) state_d = ST_FDEC;
      end
      ST_FDEC: begin
        if (prev_touch) state_d = cur_touch ? ST_FMERGE : ST_SUM;
        else if (cur_touch) state_d = ST_SUM;
        else if (room) state_d = ST_SHIFT;
        else state_d = ST_SUM;
      end
      ST_FMERGE: state_d = ST_SHIFT;
      ST_SHIFT: begin
        if (rem_q == '0 && !pend_q) state_d = ST_SUM;
      end
      ST_SUM: begin
        if (!more && !pend_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    re = 1'b0; we = 1'b0; raddr = '0; waddr = '0; wdata = '0;
    ptr_d = ptr_q; idx_d = idx_q; rem_d = rem_q; nx_d = nx_q; ra_d = ra_q;
    up_d = up_q; cur_vld_d = cur_vld_q; mode_d = mode_q; status_d = status_q;
    addr_d = addr_q; size_d = size_q; prev_s_d = prev_s_q; prev_l_d = prev_l_q;
    cur_s_d = cur_s_q; cur_l_d = cur_l_q; count_d = count_q; peak_d = peak_q;
    dropc_d = dropc_q; dropb_d = dropb_q; total_d = total_q; granted_d = granted_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          mode_d    = req_i.mode;
          addr_d    = req_i.addr;
          size_d    = req_i.size;
          ptr_d     = '0;
          total_d   = '0;
          granted_d = '0;
          status_d  = STAT_OK;
          cur_vld_d = 1'b0;
        end
      end
      ST_ASCAN: begin
        if (a_hit) begin
          granted_d = rstart;
          if (a_exact) begin
            nx_d = ptr_q;
            rem_d = count_q - ptr_q;
            up_d = 1'b0;
          end else begin
            we = 1'b1;
            waddr = IdxW'(ptr_q - 1'b1);
            wdata = {rlen - size_q, rstart + size_q};
          end
          ptr_d = '0;
        end else if (more) begin
          re = 1'b1;
          raddr = ptr_q[IdxW-1:0];
          ptr_d = ptr_q + 1'b1;
        end else begin
          status_d = STAT_NOFIT;
          ptr_d = '0;
        end
      end
      ST_FSCAN: begin
        if (f_gt) begin
          idx_d = ptr_q - 1'b1;
          cur_s_d = rstart;
          cur_l_d = rlen;
          cur_vld_d = 1'b1;
        end else begin
          if (pend_q) begin
            prev_s_d = rstart;
            prev_l_d = rlen;
          end
          if (more) begin
            re = 1'b1;
            raddr = ptr_q[IdxW-1:0];
            ptr_d = ptr_q + 1'b1;
          end else begin
            idx_d = ptr_q;
          end
        end
      end
      ST_FDEC: begin
        ptr_d = '0;
        if (prev_touch) begin
          prev_l_d = sat_add(prev_l_q, size_q);
          we = 1'b1;
          waddr = IdxW'(idx_q - 1'b1);
          wdata = {sat_add(prev_l_q, size_q), prev_s_q};
        end else if (cur_touch) begin
          we = 1'b1;
          waddr = idx_q[IdxW-1:0];
          wdata = {sat_add(cur_l_q, size_q), addr_q};
        end else if (room) begin
          nx_d = count_q - 1'b1;
          rem_d = count_q - idx_q;
          up_d = 1'b1;
        end else begin
          dropc_d = sat_add(dropc_q, 32'd1);
          dropb_d = sat_add(dropb_q, size_q);
          status_d = STAT_DROP;
        end
      end
      ST_FMERGE: begin
        we = 1'b1;
        waddr = IdxW'(idx_q - 1'b1);
        wdata = {sat_add(prev_l_q, cur_l_q), prev_s_q};
        nx_d = idx_q + 1'b1;
        rem_d = count_q - 1'b1 - idx_q;
        up_d = 1'b0;
      end
      ST_SHIFT: begin
        if (pend_q) begin
          we = 1'b1;
          waddr = up_q ? ra_q + 1'b1 : ra_q - 1'b1;
          wdata = rdata_q;
        end
        if (rem_q != '0) begin
          re = 1'b1;
          raddr = nx_q[IdxW-1:0];
          ra_d = nx_q[IdxW-1:0];
          nx_d = up_q ? nx_q - 1'b1 : nx_q + 1'b1;
          rem_d = rem_q - 1'b1;
        end else if (!pend_q) begin
          ptr_d = '0;
          if (up_q) begin
            we = 1'b1;
            waddr = idx_q[IdxW-1:0];
            wdata = {size_q, addr_q};
            count_d = count_q + 1'b1;
            if (peak_q < count_q + 1'b1) peak_d = count_q + 1'b1;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
      end
      ST_SUM: begin
        if (pend_q) total_d = sat_add(total_q, rlen);
        if (more) begin
          re = 1'b1;
          raddr = ptr_q[IdxW-1:0];
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      count_q <= '0;
      peak_q  <= '0;
      dropc_q <= '0;
      dropb_q <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= re;
      count_q <= count_d;
      peak_q  <= peak_d;
      dropc_q <= dropc_d;
      dropb_q <= dropb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d; idx_q <= idx_d; rem_q <= rem_d; nx_q <= nx_d; ra_q <= ra_d;
    up_q <= up_d; cur_vld_q <= cur_vld_d; mode_q <= mode_d; status_q <= status_d;
    addr_q <= addr_d; size_q <= size_d; prev_s_q <= prev_s_d; prev_l_q <= prev_l_d;
    cur_s_q <= cur_s_d; cur_l_q <= cur_l_d; total_q <= total_d; granted_q <= granted_d;
  end

  assign req_ready_o = state_q == ST_IDLE;
  assign rsp_valid_o = state_q == ST_DONE;

  always_comb begin
    rsp_o.granted_addr = (mode_q == MODE_ALLOC) ? granted_q : '0;
    rsp_o.status       = status_q;
    rsp_o.free_total   = total_q;
    rsp_o.entries_used = count_q;
    rsp_o.peak_entries = peak_q;
    rsp_o.lost_blocks  = dropc_q;
    rsp_o.lost_bytes   = dropb_q;
  end

endmodule

/* sim/free_list_allocator_unit_test.sv */
// Self-checking testbench for free_list_allocator_unit: directed and random requests,
// predicted by a behavioral copy of the free-region table and compared word by word.
// Depends on fla_pkg and the allocator RTL.
`timescale 1ns / 100ps

module free_list_allocator_unit_test;
  import fla_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned DrainCycles = 260;
  localparam int unsigned IdleLimit = 20000;

  typedef struct {
    logic [31:0] granted_addr;
    logic [1:0]  status;
    logic [31:0] free_total;
    logic [6:0]  entries_used;
    logic [6:0]  peak_entries;
    logic [31:0] lost_blocks;
    logic [31:0] lost_bytes;
  } alloc_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_wdata_i = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [63:0]  s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [143:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  free_list_allocator_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  always #5 clk_i = ~clk_i;

  logic [31:0] free_start [TableEntries];
  logic [31:0] free_len [TableEntries];
  int unsigned free_cnt, free_peak;
  logic [31:0] drop_cnt, drop_bytes;
  logic        page_round;

  alloc_result_t pending_results[$];
  logic [31:0]   live_addr[$];
  logic [31:0]   live_size[$];

  int unsigned errors, idle_cycles;
  int unsigned send_idle_pct, recv_stall_pct, hold_off;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  function automatic void drop_entry(int unsigned k);
    if (free_cnt == 0) return;
    free_cnt--;
    for (int unsigned i = k; i < free_cnt; i++) begin
      free_start[i] = free_start[i + 1];
      free_len[i] = free_len[i + 1];
    end
  endfunction

  function automatic alloc_result_t predict_request(logic [1:0] mode, logic [31:0] addr,
                                                    logic [31:0] size_in);
    alloc_result_t r;
    logic [31:0] size;
    logic [32:0] blk_end;
    int unsigned i;
    size = size_in;
    if (page_round) size = (size > PageBase) ? PageBase : ((size + PageMask) & PageBase);
    r = '{default: '0};
    r.status = STAT_OK;
    if (mode == MODE_ALLOC) begin
      r.status = STAT_NOFIT;
      for (i = 0; i < free_cnt; i++) begin
        if (free_len[i] >= size) begin
          r.granted_addr = free_start[i];
          r.status = STAT_OK;
          free_start[i] = free_start[i] + size;
          free_len[i] = free_len[i] - size;
          if (free_len[i] == 0) drop_entry(i);
          live_addr.push_back(r.granted_addr);
          live_size.push_back(size);
          break;
        end
      end
    end else if (mode == MODE_FREE) begin
      blk_end = {1'b0, addr} + {1'b0, size};
      for (i = 0; i < free_cnt; i++) if (free_start[i] > addr) break;
      if (i > 0 && ({1'b0, free_start[i-1]} + {1'b0, free_len[i-1]}) == {1'b0, addr}) begin
        free_len[i-1] = add_sat(free_len[i-1], size);
        if (i < free_cnt && blk_end == {1'b0, free_start[i]}) begin
          free_len[i-1] = add_sat(free_len[i-1], free_len[i]);
          drop_entry(i);
        end
      end else if (i < free_cnt && blk_end == {1'b0, free_start[i]}) begin
        free_start[i] = addr;
        free_len[i] = add_sat(free_len[i], size);
      end else if (free_cnt < TableEntries) begin
        for (int unsigned j = free_cnt; j > i; j--) begin
          free_start[j] = free_start[j - 1];
          free_len[j] = free_len[j - 1];
        end
        free_cnt++;
        if (free_peak < free_cnt) free_peak = free_cnt;
        free_start[i] = addr;
        free_len[i] = size;
      end else begin
        drop_cnt = add_sat(drop_cnt, 32'd1);
        drop_bytes = add_sat(drop_bytes, size);
        r.status = STAT_DROP;
      end
    end
    for (i = 0; i < free_cnt; i++) r.free_total = add_sat(r.free_total, free_len[i]);
    r.entries_used = free_cnt[6:0];
    r.peak_entries = free_peak[6:0];
    r.lost_blocks = drop_cnt;
    r.lost_bytes = drop_bytes;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  // Send one word; idle first at random, then hold until accepted.
  task automatic send_word(logic [1:0] mode, logic [31:0] addr, logic [31:0] size);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {size, addr};
    s_axis_tuser_i <= mode;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(predict_request(mode, addr, size));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_page_round(logic value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    page_round = value;
  endtask

  always @(posedge clk_i) begin
    alloc_result_t want;
    logic [143:0] d;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      d = m_axis_tdata_o;
      if (pending_results.size() == 0) begin
        $display("result word with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (d[31:0] !== want.granted_addr)
          report_mismatch("granted_addr", d[31:0], want.granted_addr);
        if (m_axis_tuser_o !== want.status)
          report_mismatch("status", 32'(m_axis_tuser_o), 32'(want.status));
        if (d[63:32] !== want.free_total)
          report_mismatch("free_total", d[63:32], want.free_total);
        if (d[70:64] !== want.entries_used)
          report_mismatch("entries_used", 32'(d[70:64]), 32'(want.entries_used));
        if (d[77:71] !== want.peak_entries)
          report_mismatch("peak_entries", 32'(d[77:71]), 32'(want.peak_entries));
        if (d[109:78] !== want.lost_blocks)
          report_mismatch("lost_blocks", d[109:78], want.lost_blocks);
        if (d[141:110] !== want.lost_bytes)
          report_mismatch("lost_bytes", d[141:110], want.lost_bytes);
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("free_list_allocator_unit_test NOT OK");
      $finish;
    end
  end

  task automatic test_basic_ops();
    send_word(MODE_QUERY, 32'h0, 32'h0);
    send_word(MODE_ALLOC, 32'h0, 32'h10);
    send_word(MODE_FREE, 32'h1000, 32'h1000);
    send_word(MODE_FREE, 32'h3000, 32'h1000);
    send_word(MODE_FREE, 32'h2000, 32'h1000);
    send_word(MODE_FREE, 32'h0800, 32'h0800);
    send_word(MODE_FREE, 32'h4000, 32'h0);
    send_word(MODE_ALLOC, 32'hffff_ffff, 32'h0);
    send_word(MODE_ALLOC, 32'h0, 32'h100);
    send_word(MODE_ALLOC, 32'h0, 32'h3700);
    send_word(MODE_ALLOC, 32'h0, 32'hffff_ffff);
    send_word(MODE_SPARE, 32'hffff_ffff, 32'hffff_ffff);
    send_word(MODE_FREE, 32'h9000, 32'h100);
    send_word(MODE_FREE, 32'h9000, 32'h100);
    send_word(MODE_FREE, 32'h0, 32'hffff_ffff);
    send_word(MODE_FREE, 32'hffff_ffff, 32'h5);
    send_word(MODE_QUERY, 32'h0, 32'h0);
    send_word(MODE_ALLOC, 32'h0, 32'hffff_ffff);
  endtask

  task automatic test_page_round();
    write_page_round(1'b1);
    send_word(MODE_ALLOC, 32'h0, 32'h1);
    send_word(MODE_ALLOC, 32'h0, 32'h0);
    send_word(MODE_ALLOC, 32'h0, 32'hffff_f001);
    send_word(MODE_FREE, 32'h1000_0000, 32'hffff_ffff);
    send_word(MODE_FREE, 32'h0000_0123, 32'h1001);
    send_word(MODE_ALLOC, 32'h0, 32'h1000);
  endtask

  task automatic test_table_full();
    write_page_round(1'b0);
    for (int i = 0; i < 72; i++)
      send_word(MODE_FREE, 32'h8000_0000 + i * 32'h100, 32'h10 + i);
  endtask

  task automatic test_backpressure();
    @(negedge clk_i);
    hold_off = 3000;
    for (int i = 0; i < 20; i++) send_word(MODE_ALLOC, 32'h0, $urandom_range(32'h40));
    wait_drained();
    send_word(MODE_QUERY, 32'h0, 32'h0);
  endtask

  task automatic test_random(int unsigned count);
    int unsigned pick, k;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_word(MODE_ALLOC, $urandom, $urandom_range(32'h3000));
      end else if (pick < 70 && live_addr.size() != 0) begin
        k = $urandom_range(live_addr.size() - 1);
        send_word(MODE_FREE, live_addr[k], live_size[k]);
        live_addr.delete(k);
        live_size.delete(k);
      end else if (pick < 80) begin
        send_word(MODE_FREE, $urandom & 32'h00ff_fff0, $urandom_range(32'h4000));
      end else if (pick < 88) begin
        send_word($urandom_range(1) ? MODE_QUERY : MODE_SPARE, $urandom, $urandom);
      end else begin
        send_word(2'($urandom_range(3)), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    free_cnt = 0;
    free_peak = 0;
    drop_cnt = '0;
    drop_bytes = '0;
    page_round = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    write_page_round(1'b0);
    test_basic_ops();
    test_page_round();
    test_table_full();
    test_backpressure();
    send_word(MODE_FREE, 32'h0010_0000, 32'h0040_0000);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1 || p == 3) ? 72 : (p == 2 ? 7 : 0);
      recv_stall_pct = (p == 2 || p == 3) ? 72 : (p == 2 ? 7 : 0);
      if (p == 3) begin
        send_idle_pct = 7;
        recv_stall_pct = 7;
      end
      if (p == 2) send_idle_pct = 0;
      write_page_round(p[0]);
      test_random(310);
    end
    wait_drained();
    if (errors == 0)
      $display("free_list_allocator_unit_test OK");
    else
      $display("free_list_allocator_unit_test NOT OK");
    $finish;
  end

endmodule

/* files.f */
src/fla_pkg.sv
src/fla_engine.sv
src/free_list_allocator_unit.sv
sim/free_list_allocator_unit_test.sv
